@@ rtl/ips_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_pkg
// Shared widths, types and register codes for the interrupt priority select.
// ----------------------------------------------------------------------------
package ips_pkg;

	localparam int PRIORITY_BITS  = 8;
	localparam int SOURCE_ID_BITS = 10;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = PRIORITY_BITS;

	typedef logic [PRIORITY_BITS-1:0]  prio_t;
	typedef logic [SOURCE_ID_BITS-1:0] src_id_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_DELIVERY  = 2'd1,
		REG_FORCE     = 2'd2,
		REG_DOMAIN    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic qualifies;
		logic better;
	} qual_t;

endpackage

@@ rtl/ips_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_channels
// Valid/ready channels: source beats in, selection results out.
// ----------------------------------------------------------------------------
interface ips_src_if;
	logic                  valid;
	logic                  ready;
	ips_pkg::src_id_t      source_id;
	ips_pkg::prio_t        source_priority;
	logic                  targets_hart;
	logic                  is_pending;
	logic                  is_enabled;
	logic                  last_source;

	modport source (
		output valid, source_id, source_priority, targets_hart, is_pending,
		       is_enabled, last_source,
		input  ready
	);
	modport sink (
		input  valid, source_id, source_priority, targets_hart, is_pending,
		       is_enabled, last_source,
		output ready
	);
endinterface

interface ips_res_if;
	logic                  valid;
	logic                  ready;
	ips_pkg::src_id_t      top_source;
	ips_pkg::prio_t        top_priority;
	logic                  interrupt_line;

	modport source (
		output valid, top_source, top_priority, interrupt_line,
		input  ready
	);
	modport sink (
		input  valid, top_source, top_priority, interrupt_line,
		output ready
	);
endinterface

@@ rtl/ips_qualify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_qualify
// Source qualification and compare against the running best priority.
// ----------------------------------------------------------------------------
module ips_qualify (
	input  ips_pkg::src_id_t source_id,
	input  ips_pkg::prio_t   source_priority,
	input  logic             targets_hart,
	input  logic             is_pending,
	input  logic             is_enabled,
	input  ips_pkg::prio_t   threshold,
	input  ips_pkg::prio_t   best_priority,
	output ips_pkg::prio_t   legal_priority,
	output ips_pkg::qual_t   qual
);

	logic under;

	// priority zero is not stored in direct mode: read as one
	assign legal_priority = (source_priority == '0) ? ips_pkg::prio_t'(1) : source_priority;

	assign under = (threshold == '0) || (legal_priority < threshold);

	assign qual.qualifies = (source_id != '0) && targets_hart && is_pending && is_enabled
	                        && under;
	assign qual.better    = (best_priority == '0) || (legal_priority < best_priority);

endmodule

@@ rtl/ips_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_scan
// Running best of the scan and the result register.
// ----------------------------------------------------------------------------
module ips_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             last,
	input  ips_pkg::qual_t   qual,
	input  ips_pkg::src_id_t source_id,
	input  ips_pkg::prio_t   legal_priority,
	input  logic             delivery_enable,
	input  logic             force_interrupt,
	input  logic             domain_enable,
	output ips_pkg::prio_t   best_priority,
	output logic             res_free,
	output logic             res_load,
	ips_res_if.source        res
);

	ips_pkg::prio_t   best_prio_q;
	ips_pkg::src_id_t best_src_q;
	logic             any_q;
	ips_pkg::prio_t   nb_prio;
	ips_pkg::src_id_t nb_src;
	logic             nb_any;
	logic             res_valid_q;
	ips_pkg::src_id_t res_src_q;
	ips_pkg::prio_t   res_prio_q;
	logic             res_line_q;

	assign best_priority = best_prio_q;
	assign res_free      = !res_valid_q || res.ready;
	assign res_load      = step && last;

	always_comb begin
		nb_prio = best_prio_q;
		nb_src  = best_src_q;
		nb_any  = any_q;
		if (qual.qualifies) begin
			nb_any = 1'b1;
			if (qual.better) begin
				nb_prio = legal_priority;
				nb_src  = source_id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_prio_q <= '0;
			best_src_q  <= '0;
			any_q       <= 1'b0;
		end else if (step) begin
			if (last) begin
				best_prio_q <= '0;
				best_src_q  <= '0;
				any_q       <= 1'b0;
			end else begin
				best_prio_q <= nb_prio;
				best_src_q  <= nb_src;
				any_q       <= nb_any;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_src_q  <= nb_src;
			res_prio_q <= nb_prio;
			res_line_q <= domain_enable && (force_interrupt || (delivery_enable && nb_any));
		end
	end

	assign res.valid          = res_valid_q;
	assign res.top_source     = res_src_q;
	assign res.top_priority   = res_prio_q;
	assign res.interrupt_line = res_line_q;

endmodule

@@ rtl/interrupt_priority_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_priority_select
// Top-interrupt selection for one hart in direct mode.
//
//   channel   dir  beat
//   src       in   one interrupt source; last_source closes the scan
//   res       out  top_source, top_priority, interrupt_line, one per scan
//   cfg       in   write_enable / reg_index / write_data, no read-back
//
// One source beat per cycle unless a closing beat waits. A beat is registered,
// then compared against the running best in one step; the closing beat loads
// the result register once the result slot is free. Reset clears config, scan
// state and valid flags. A stalled result holds a closing beat in stage 1, and
// the source side with it; non-closing beats in stage 1 never wait.
// ----------------------------------------------------------------------------
module interrupt_priority_select (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ips_src_if.sink                              src,
	ips_res_if.source                            res,
	input  logic                                 write_enable,
	input  logic [ips_pkg::CFG_INDEX_BITS-1:0]   reg_index,
	input  logic [ips_pkg::CFG_DATA_BITS-1:0]    write_data
);

	ips_pkg::prio_t   threshold_q;
	logic             delivery_q;
	logic             force_q;
	logic             domain_q;

	logic             v_s1;
	ips_pkg::src_id_t id_s1;
	ips_pkg::prio_t   prio_s1;
	logic             targets_s1;
	logic             pending_s1;
	logic             enabled_s1;
	logic             last_s1;

	logic             s1_adv;
	logic             res_free;
	logic             res_load;
	ips_pkg::prio_t   best_priority;
	ips_pkg::prio_t   legal_priority;
	ips_pkg::qual_t   qual;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			delivery_q  <= 1'b0;
			force_q     <= 1'b0;
			domain_q    <= 1'b0;
		end else if (write_enable) begin
			case (ips_pkg::cfg_reg_t'(reg_index))
				ips_pkg::REG_THRESHOLD: threshold_q <= write_data;
				ips_pkg::REG_DELIVERY:  delivery_q  <= write_data[0];
				ips_pkg::REG_FORCE:     force_q     <= write_data[0];
				ips_pkg::REG_DOMAIN:    domain_q    <= write_data[0];
				default: ;
			endcase
		end
	end

	assign s1_adv    = v_s1 && (!last_s1 || res_free);
	assign src.ready = !v_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src.valid && src.ready) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			id_s1      <= src.source_id;
			prio_s1    <= src.source_priority;
			targets_s1 <= src.targets_hart;
			pending_s1 <= src.is_pending;
			enabled_s1 <= src.is_enabled;
			last_s1    <= src.last_source;
		end
	end

	ips_qualify u_qualify (
		.source_id       (id_s1),
		.source_priority (prio_s1),
		.targets_hart    (targets_s1),
		.is_pending      (pending_s1),
		.is_enabled      (enabled_s1),
		.threshold       (threshold_q),
		.best_priority   (best_priority),
		.legal_priority  (legal_priority),
		.qual            (qual)
	);

	ips_scan u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (s1_adv),
		.last            (last_s1),
		.qual            (qual),
		.source_id       (id_s1),
		.legal_priority  (legal_priority),
		.delivery_enable (delivery_q),
		.force_interrupt (force_q),
		.domain_enable   (domain_q),
		.best_priority   (best_priority),
		.res_free        (res_free),
		.res_load        (res_load),
		.res             (res)
	);

	// non-closing beats never wait on the result side
	a_open_beat_flows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !last_s1 |-> s1_adv)
		else $error("open beat stalled in stage 1");

	// no source selected means no priority reported
	a_none_zero_prio: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.top_source == '0) |-> (res.top_priority == '0))
		else $error("priority reported without a source");

	// a taken result with nothing behind it leaves the register empty
	a_res_drains: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !res_load |=> !res.valid)
		else $error("result repeated");

	// a closing beat is only stepped into a free result slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_free)
		else $error("result overwritten");

endmodule

@@ tb/sv/ips_selection_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_selection_checker
// Watches the source, result and register-write ports of the interrupt
// priority select. It tracks the register settings and the running best
// source of each scan, queues the selection that each closing beat should
// produce, and compares every result beat with the oldest queued selection.
// ----------------------------------------------------------------------------
module ips_selection_checker
	import ips_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	ips_src_if                        src,
	ips_res_if                        res,
	input  logic                      write_enable,
	input  logic [CFG_INDEX_BITS-1:0] reg_index,
	input  logic [CFG_DATA_BITS-1:0]  write_data,
	output int unsigned               failures,
	output int unsigned               outstanding,
	output int unsigned               results_checked,
	output int unsigned               lines_high
);

	localparam int MAX_REPORTS = 10;

	typedef struct {
		src_id_t top_source;
		prio_t   top_priority;
		logic    interrupt_line;
	} selection_t;

	selection_t  expected_selections[$];

	prio_t       threshold;
	logic        delivery_en;
	logic        force_irq;
	logic        domain_en;

	prio_t       best_prio;
	src_id_t     best_src;
	logic        any_hit;

	int unsigned fail_count;
	int unsigned result_count;
	int unsigned high_count;

	always @(posedge clk or negedge arst_n) begin : track
		prio_t      eff_prio;
		logic       under;
		selection_t sel;
		if (!arst_n) begin
			threshold   = '0;
			delivery_en = 1'b0;
			force_irq   = 1'b0;
			domain_en   = 1'b0;
			best_prio   = '0;
			best_src    = '0;
			any_hit     = 1'b0;
			expected_selections.delete();
			failures        <= fail_count;
			outstanding     <= 0;
			results_checked <= result_count;
			lines_high      <= high_count;
		end else begin
			if (write_enable) begin
				case (cfg_reg_t'(reg_index))
					REG_THRESHOLD: threshold   = write_data[PRIORITY_BITS-1:0];
					REG_DELIVERY:  delivery_en = write_data[0];
					REG_FORCE:     force_irq   = write_data[0];
					REG_DOMAIN:    domain_en   = write_data[0];
					default: ;
				endcase
			end

			if (res.valid && res.ready) begin
				if (expected_selections.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("[%0t] unexpected result beat: src=%0d prio=%0d line=%0b",
							$time, res.top_source, res.top_priority, res.interrupt_line);
				end else begin
					sel = expected_selections.pop_front();
					if (res.top_source !== sel.top_source ||
							res.top_priority !== sel.top_priority ||
							res.interrupt_line !== sel.interrupt_line) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"[%0t] selection mismatch: expected src=%0d prio=%0d ",
								"line=%0b, got src=%0d prio=%0d line=%0b"}, $time,
								sel.top_source, sel.top_priority, sel.interrupt_line,
								res.top_source, res.top_priority, res.interrupt_line);
					end
					result_count++;
					if (sel.interrupt_line)
						high_count++;
				end
			end

			if (src.valid && src.ready) begin
				// priority 0 is not stored in direct mode; it counts as 1
				eff_prio = (src.source_priority == '0) ? prio_t'(1) : src.source_priority;
				under    = (threshold == '0) || (eff_prio < threshold);
				if (src.source_id != '0 && src.targets_hart && src.is_pending &&
						src.is_enabled && under) begin
					any_hit = 1'b1;
					if (best_prio == '0 || eff_prio < best_prio) begin
						best_prio = eff_prio;
						best_src  = src.source_id;
					end
				end
				if (src.last_source) begin
					sel.top_source     = best_src;
					sel.top_priority   = best_prio;
					sel.interrupt_line = domain_en & (force_irq | (delivery_en & any_hit));
					expected_selections.push_back(sel);
					best_prio = '0;
					best_src  = '0;
					any_hit   = 1'b0;
				end
			end

			failures        <= fail_count;
			outstanding     <= expected_selections.size();
			results_checked <= result_count;
			lines_high      <= high_count;
		end
	end

endmodule

@@ tb/sv/interrupt_priority_select_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_priority_select_tb
// Drives source scans into the interrupt priority select under a series of
// register settings, with random gaps on the source side and random stalls
// on the result side. A short directed part covers priority zero, source id
// zero, ties, threshold limits and the interrupt line terms; random scans
// follow. The selection checker predicts and compares; this module makes the
// stimulus, runs the stall watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module interrupt_priority_select_tb;
	import ips_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int TARGET_BEATS  = 1850;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 2000;

	logic                      clk;
	logic                      arst_n;
	logic                      write_enable;
	logic [CFG_INDEX_BITS-1:0] reg_index;
	logic [CFG_DATA_BITS-1:0]  write_data;
	logic                      steady;
	prio_t                     cur_threshold;

	int unsigned beats_sent;
	int unsigned scans_sent;
	int unsigned settings_applied;
	int unsigned failures;
	int unsigned outstanding;
	int unsigned results_checked;
	int unsigned lines_high;

	ips_src_if src_ch();
	ips_res_if res_ch();

	interrupt_priority_select uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src          (src_ch),
		.res          (res_ch),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	ips_selection_checker sel_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.src             (src_ch),
		.res             (res_ch),
		.write_enable    (write_enable),
		.reg_index       (reg_index),
		.write_data      (write_data),
		.failures        (failures),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.lines_high      (lines_high)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic src_id_t pick_id();
		case ($urandom_range(0, 39))
			0:       return '0;
			1:       return src_id_t'(1);
			2:       return '1;
			default: return src_id_t'($urandom_range(1, 1023));
		endcase
	endfunction

	function automatic prio_t pick_priority();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return cur_threshold;
			3:       return cur_threshold - prio_t'(1);
			4, 5:    return prio_t'($urandom_range(1, 4));
			default: return prio_t'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] flag_word(input logic flag);
		return {(CFG_DATA_BITS-1)'($urandom), flag};
	endfunction

	task automatic send_beat(input src_id_t id, input prio_t pr,
			input logic tgt, input logic pend, input logic en, input logic last);
		int unsigned gap;
		src_ch.valid           <= 1'b1;
		src_ch.source_id       <= id;
		src_ch.source_priority <= pr;
		src_ch.targets_hart    <= tgt;
		src_ch.is_pending      <= pend;
		src_ch.is_enabled      <= en;
		src_ch.last_source     <= last;
		@(posedge clk);
		while (!src_ch.ready)
			@(posedge clk);
		beats_sent++;
		if (last)
			scans_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			src_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every queued selection, then let non-closing beats clear the pipe
	task automatic drain();
		src_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input prio_t thr, input logic del, input logic frc,
			input logic dom);
		write_enable <= 1'b1;
		reg_index    <= REG_THRESHOLD;
		write_data   <= thr;
		@(posedge clk);
		reg_index    <= REG_DELIVERY;
		write_data   <= flag_word(del);
		@(posedge clk);
		reg_index    <= REG_FORCE;
		write_data   <= flag_word(frc);
		@(posedge clk);
		reg_index    <= REG_DOMAIN;
		write_data   <= flag_word(dom);
		@(posedge clk);
		write_enable <= 1'b0;
		cur_threshold = thr;
		settings_applied++;
	endtask

	task automatic random_config();
		prio_t thr;
		case ($urandom_range(0, 5))
			0:       thr = '0;
			1:       thr = prio_t'(1);
			2:       thr = '1;
			default: thr = prio_t'($urandom);
		endcase
		apply_config(thr, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
			$urandom_range(0, 4) != 0);
	endtask

	task automatic random_scan();
		int unsigned len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
		for (int unsigned i = 0; i < len; i++)
			send_beat(pick_id(), pick_priority(), $urandom_range(0, 5) != 0,
				$urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0, i == len - 1);
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!steady && $urandom_range(0, 2) == 0) begin
				res_ch.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] no beat accepted for %0d cycles", $time, STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		arst_n                 <= 1'b0;
		write_enable           <= 1'b0;
		reg_index              <= REG_THRESHOLD;
		write_data             <= '0;
		src_ch.valid           <= 1'b0;
		src_ch.source_id       <= '0;
		src_ch.source_priority <= '0;
		src_ch.targets_hart    <= 1'b0;
		src_ch.is_pending      <= 1'b0;
		src_ch.is_enabled      <= 1'b0;
		src_ch.last_source     <= 1'b0;
		steady           = 1'b0;
		cur_threshold    = '0;
		beats_sent       = 0;
		scans_sent       = 0;
		settings_applied = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: line held low by the domain gate
		send_beat('1, '1, 1'b1, 1'b1, 1'b1, 1'b1);
		drain();
		apply_config('0, 1'b1, 1'b0, 1'b1);
		// priority 0 ties with 1, earlier wins; id 0 only closes the scan
		send_beat(src_id_t'(5), '0, 1'b1, 1'b1, 1'b1, 1'b0);
		send_beat(src_id_t'(7), prio_t'(1), 1'b1, 1'b1, 1'b1, 1'b0);
		send_beat('0, '0, 1'b1, 1'b1, 1'b1, 1'b1);
		// each qualifying bit missing in turn
		send_beat(src_id_t'(9), prio_t'(3), 1'b0, 1'b1, 1'b1, 1'b0);
		send_beat(src_id_t'(10), prio_t'(2), 1'b1, 1'b0, 1'b1, 1'b0);
		send_beat(src_id_t'(11), prio_t'(2), 1'b1, 1'b1, 1'b0, 1'b1);
		send_beat('0, prio_t'(9), 1'b1, 1'b1, 1'b1, 1'b1);
		send_beat(src_id_t'(1), prio_t'(200), 1'b1, 1'b1, 1'b1, 1'b0);
		send_beat(src_id_t'(2), prio_t'(200), 1'b1, 1'b1, 1'b1, 1'b0);
		send_beat(src_id_t'(3), prio_t'(100), 1'b1, 1'b1, 1'b1, 1'b1);
		drain();
		apply_config('1, 1'b0, 1'b1, 1'b1);
		send_beat(src_id_t'(4), '1, 1'b1, 1'b1, 1'b1, 1'b0);
		send_beat(src_id_t'(6), prio_t'(254), 1'b1, 1'b1, 1'b1, 1'b1);
		drain();
		apply_config(prio_t'(1), 1'b1, 1'b0, 1'b1);
		send_beat(src_id_t'(8), '0, 1'b1, 1'b1, 1'b1, 1'b1);
		drain();
		apply_config('0, 1'b1, 1'b1, 1'b0);
		send_beat(src_id_t'(12), prio_t'(50), 1'b1, 1'b1, 1'b1, 1'b1);
		drain();
		apply_config(prio_t'(128), 1'b1, 1'b0, 1'b1);
		send_beat(src_id_t'(13), prio_t'(127), 1'b1, 1'b1, 1'b1, 1'b0);
		send_beat(src_id_t'(14), prio_t'(128), 1'b1, 1'b1, 1'b1, 1'b1);

		while (beats_sent < TARGET_BEATS) begin
			drain();
			random_config();
			steady = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(10, 30)) random_scan();
		end
		drain();

		$display("Sent %0d source beats in %0d scans over %0d register settings.",
			beats_sent, scans_sent, settings_applied);
		$display("Checked %0d selections, %0d with the interrupt line raised; %0d mismatches.",
			results_checked, lines_high, failures);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
